// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL files (used by priority_voice_allocator)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every rising clock edge outside reset
`define PVA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// cond must never be true outside reset
`define PVA_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PVA_ASSERT(label, clk, rst_n, prop, msg)
`define PVA_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/pva_pkg.sv =====
package pva_pkg;

    // sizing
    localparam int CHANNEL_COUNT_DEF = 16;
    localparam int SOUND_IDS         = 64;
    localparam int SOUND_W           = 6;
    localparam int LEVEL_W           = 2;
    localparam int ELAPSED_W         = 16;
    localparam int CHAN_OUT_W        = 4;
    localparam int COUNT_W           = 7;

    // request actions
    localparam logic [1:0] ACT_PLAY = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_END  = 2'd2;

    // priority levels
    localparam logic [1:0] LVL_LOWEST  = 2'd0;
    localparam logic [1:0] LVL_LOW     = 2'd1;
    localparam logic [1:0] LVL_HIGH    = 2'd2;
    localparam logic [1:0] LVL_HIGHEST = 2'd3;

    // outcome codes
    localparam logic [2:0] OUT_GRANTED    = 3'd0;
    localparam logic [2:0] OUT_DISABLED   = 3'd1;
    localparam logic [2:0] OUT_BAD_ID     = 3'd2;
    localparam logic [2:0] OUT_DUPLICATE  = 3'd3;
    localparam logic [2:0] OUT_PLAYING    = 3'd4;
    localparam logic [2:0] OUT_NO_CHANNEL = 3'd5;
    localparam logic [2:0] OUT_NOT_PLAY   = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_AUDIO_EN   = 2'd0;
    localparam logic [1:0] CFG_DUP_WINDOW = 2'd1;
    localparam logic [1:0] CFG_SOUND_CNT  = 2'd2;

    // configuration reset values
    localparam logic [ELAPSED_W-1:0] DUP_WINDOW_RST = 16'd50;
    localparam logic [COUNT_W-1:0]   SOUND_CNT_RST  = 7'd64;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    // one channel entry in the channel memory
    typedef struct packed {
        logic [SOUND_W-1:0]   sound;
        logic [LEVEL_W-1:0]   level;
        logic [ELAPSED_W-1:0] elapsed;
    } t_entry;

    // per-channel test results from the compare unit
    typedef struct packed {
        logic dup;       // same sound, playing, inside the window
        logic playing;   // same sound, playing
        logic idle;      // channel not playing
        logic diff;      // channel holds another sound
        logic high_ok;   // a high request may take this channel
    } t_cmp_flags;

    // one result item
    typedef struct packed {
        logic                  granted;
        logic [CHAN_OUT_W-1:0] channel;
        logic [2:0]            outcome;
    } t_result;

endpackage

// ===== rtl/pva_chan_mem.sv =====
module pva_chan_mem #(
    parameter int DEPTH = pva_pkg::CHANNEL_COUNT_DEF,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  pva_pkg::t_entry  i_wr_data,
    output pva_pkg::t_entry  o_rd_data
);

    pva_pkg::t_entry r_mem [DEPTH];
    pva_pkg::t_entry r_rd_data;
    logic [DEPTH-1:0] r_written;
    logic             r_rd_written;

    // storage array, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // written flags: an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_written <= r_written[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_written ? r_rd_data : '0;

endmodule

// ===== rtl/pva_entry_cmp.sv =====
module pva_entry_cmp (
    input  pva_pkg::t_entry                    i_entry,
    input  logic                               i_active,
    input  logic [pva_pkg::SOUND_W-1:0]        i_sound_id,
    input  logic [pva_pkg::ELAPSED_W-1:0]      i_window,
    output pva_pkg::t_cmp_flags                o_flags,
    output logic [pva_pkg::ELAPSED_W-1:0]      o_elapsed_next
);

    logic same;

    assign same = (i_entry.sound == i_sound_id);

    // channel tests for one scanned entry
    always_comb begin
        o_flags.dup     = i_active && same && (i_entry.elapsed <= i_window);
        o_flags.playing = i_active && same;
        o_flags.idle    = !i_active;
        o_flags.diff    = !same;
        o_flags.high_ok = (i_entry.level < pva_pkg::LVL_HIGH) ||
                          ((i_entry.level == pva_pkg::LVL_HIGH) && !i_active);
    end

    // saturating millisecond counter
    assign o_elapsed_next = (i_entry.elapsed == pva_pkg::ELAPSED_MAX) ?
                            i_entry.elapsed : (i_entry.elapsed + 1'b1);

endmodule

// ===== rtl/priority_voice_allocator.sv =====
// Channel   Handshake                    Payload
// request   i_in_valid / o_in_ready      i_action, i_sound_id, i_level, i_done_channel
// result    o_out_valid / i_out_ready    o_granted, o_channel, o_outcome
// config    i_cfg_we                     i_cfg_index, i_cfg_wdata
//
// Play requests scan the channel memory one entry per cycle through the shared
// compare unit, then go through a decision state to the result state; ticks skip the
// decision; end, unknown and refused requests go straight to the result state. The next
// request can be taken once the result is registered. One read port bounds the scan.
// Reset is synchronous, active low; it idles all channels, no clearing pass.
// A result still waiting holds the block in its final state; no request is taken meanwhile.
`include "assert_macros.svh"

module priority_voice_allocator #(
    parameter int CHANNEL_COUNT = pva_pkg::CHANNEL_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_action,
    input  logic [pva_pkg::SOUND_W-1:0]         i_sound_id,
    input  logic [pva_pkg::LEVEL_W-1:0]         i_level,
    input  logic [3:0]                          i_done_channel,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_granted,
    output logic [pva_pkg::CHAN_OUT_W-1:0]      o_channel,
    output logic [2:0]                          o_outcome,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_index,
    input  logic [pva_pkg::ELAPSED_W-1:0]       i_cfg_wdata
);

    localparam int IW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam logic [IW-1:0] LAST_CH = IW'(CHANNEL_COUNT - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_DONE   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic                              r_audio_en;
    logic [pva_pkg::ELAPSED_W-1:0]     r_dup_window;
    logic [pva_pkg::COUNT_W-1:0]       r_sound_count;

    // channel playing flags
    logic [CHANNEL_COUNT-1:0]          r_active;

    // request being worked on
    logic                              r_req_tick;
    logic [pva_pkg::SOUND_W-1:0]       r_req_sound;
    logic [pva_pkg::LEVEL_W-1:0]       r_req_level;

    // scan sequencer: issue side and data-return side
    logic                              r_issuing;
    logic [IW-1:0]                     r_idx;
    logic                              r_pv;
    logic [IW-1:0]                     r_pidx;

    // scan findings
    logic                              r_dup, r_playing;
    logic                              r_idle_found, r_diff_found, r_hi_found;
    logic [IW-1:0]                     r_idle_ch, r_diff_ch, r_hi_ch;

    // results
    pva_pkg::t_result                  r_res;
    logic                              r_out_valid;
    pva_pkg::t_result                  r_out;

    logic                              in_acc;
    logic                              out_free;
    logic                              scan_last;
    pva_pkg::t_result                  imm_res;
    logic                              imm_scan;
    logic                              active_rd;
    pva_pkg::t_entry                   rd_entry;
    pva_pkg::t_cmp_flags               flags;
    logic [pva_pkg::ELAPSED_W-1:0]     elapsed_next;
    logic                              wb_en;
    logic                              dec_granted;
    logic [IW-1:0]                     dec_pick;
    logic [2:0]                        dec_outcome;
    logic                              grant_en;
    logic                              mem_we;
    logic [IW-1:0]                     mem_waddr;
    pva_pkg::t_entry                   mem_wdata;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign scan_last   = r_pv && (r_pidx == LAST_CH);
    assign o_out_valid = r_out_valid;
    assign o_granted   = r_out.granted;
    assign o_channel   = r_out.channel;
    assign o_outcome   = r_out.outcome;

    // checks settled at accept time
    always_comb begin
        imm_res.granted = 1'b0;
        imm_res.channel = '0;
        imm_res.outcome = pva_pkg::OUT_NOT_PLAY;
        imm_scan        = 1'b0;
        case (i_action)
            pva_pkg::ACT_PLAY: begin
                if (!r_audio_en) begin
                    imm_res.outcome = pva_pkg::OUT_DISABLED;
                end else if (({1'b0, i_sound_id} >= r_sound_count) ||
                             (32'(i_sound_id) >= pva_pkg::SOUND_IDS)) begin
                    imm_res.outcome = pva_pkg::OUT_BAD_ID;
                end else begin
                    imm_scan = 1'b1;
                end
            end
            pva_pkg::ACT_TICK: begin
                imm_scan = 1'b1;
            end
            default: begin
                imm_scan = 1'b0;
            end
        endcase
    end

    // channel memory and the shared compare unit
    pva_chan_mem #(
        .DEPTH (CHANNEL_COUNT),
        .AW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   ((r_state == ST_SCAN) && r_issuing),
        .i_rd_addr (r_idx),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (mem_wdata),
        .o_rd_data (rd_entry)
    );

    assign active_rd = r_active[r_pidx];

    pva_entry_cmp u_cmp (
        .i_entry        (rd_entry),
        .i_active       (active_rd),
        .i_sound_id     (r_req_sound),
        .i_window       (r_dup_window),
        .o_flags        (flags),
        .o_elapsed_next (elapsed_next)
    );

    // channel choice from the scan findings
    always_comb begin
        dec_granted = 1'b0;
        dec_pick    = '0;
        dec_outcome = pva_pkg::OUT_NO_CHANNEL;
        if (r_req_level == pva_pkg::LVL_HIGHEST) begin
            if (r_idle_found) begin
                dec_granted = 1'b1;
                dec_pick    = r_idle_ch;
            end else if (r_diff_found) begin
                dec_granted = 1'b1;
                dec_pick    = r_diff_ch;
            end
        end else if ((r_req_level < pva_pkg::LVL_HIGH) && r_dup) begin
            dec_outcome = pva_pkg::OUT_DUPLICATE;
        end else if (((r_req_level == pva_pkg::LVL_LOWEST) ||
                      (r_req_level == pva_pkg::LVL_HIGH)) && r_playing) begin
            dec_outcome = pva_pkg::OUT_PLAYING;
        end else if (r_req_level != pva_pkg::LVL_HIGH) begin
            dec_granted = r_idle_found;
            dec_pick    = r_idle_ch;
        end else begin
            dec_granted = r_hi_found;
            dec_pick    = r_hi_ch;
        end
        if (dec_granted) begin
            dec_outcome = pva_pkg::OUT_GRANTED;
        end
    end

    // memory writes: tick write-back during the scan, new voice on a grant
    assign wb_en    = (r_state == ST_SCAN) && r_pv && r_req_tick && active_rd;
    assign grant_en = (r_state == ST_DECIDE) && dec_granted;
    assign mem_we   = wb_en || grant_en;

    always_comb begin
        if (grant_en) begin
            mem_waddr         = dec_pick;
            mem_wdata.sound   = r_req_sound;
            mem_wdata.level   = r_req_level;
            mem_wdata.elapsed = '0;
        end else begin
            mem_waddr         = r_pidx;
            mem_wdata.sound   = rd_entry.sound;
            mem_wdata.level   = rd_entry.level;
            mem_wdata.elapsed = elapsed_next;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = imm_scan ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = r_req_tick ? ST_DONE : ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_audio_en    <= 1'b1;
            r_dup_window  <= pva_pkg::DUP_WINDOW_RST;
            r_sound_count <= pva_pkg::SOUND_CNT_RST;
            r_active      <= '0;
            r_issuing     <= 1'b0;
            r_pv          <= 1'b0;
            r_out_valid   <= 1'b0;
            r_dup         <= 1'b0;
            r_playing     <= 1'b0;
            r_idle_found  <= 1'b0;
            r_diff_found  <= 1'b0;
            r_hi_found    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    pva_pkg::CFG_AUDIO_EN:   r_audio_en    <= i_cfg_wdata[0];
                    pva_pkg::CFG_DUP_WINDOW: r_dup_window  <= i_cfg_wdata;
                    pva_pkg::CFG_SOUND_CNT:  r_sound_count <= i_cfg_wdata[pva_pkg::COUNT_W-1:0];
                    default: begin
                    end
                endcase
            end

            // playing flags: channel end and grant
            for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
                if (in_acc && (i_action == pva_pkg::ACT_END) &&
                    (32'(i_done_channel) == ch)) begin
                    r_active[ch] <= 1'b0;
                end
                if (grant_en && (dec_pick == IW'(ch))) begin
                    r_active[ch] <= 1'b1;
                end
            end

            // scan issue and return
            if (in_acc) begin
                r_issuing <= imm_scan;
            end else if ((r_state == ST_SCAN) && r_issuing && (r_idx == LAST_CH)) begin
                r_issuing <= 1'b0;
            end
            r_pv <= (r_state == ST_SCAN) && r_issuing;

            // findings
            if (in_acc) begin
                r_dup        <= 1'b0;
                r_playing    <= 1'b0;
                r_idle_found <= 1'b0;
                r_diff_found <= 1'b0;
                r_hi_found   <= 1'b0;
            end else if ((r_state == ST_SCAN) && r_pv) begin
                r_dup        <= r_dup || flags.dup;
                r_playing    <= r_playing || flags.playing;
                r_idle_found <= r_idle_found || flags.idle;
                r_diff_found <= r_diff_found || flags.diff;
                r_hi_found   <= r_hi_found || flags.high_ok;
            end

            // output register
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req_tick  <= (i_action == pva_pkg::ACT_TICK);
            r_req_sound <= i_sound_id;
            r_req_level <= i_level;
            r_idx       <= '0;
            r_res       <= imm_res;
        end else if ((r_state == ST_SCAN) && r_issuing && (r_idx != LAST_CH)) begin
            r_idx <= r_idx + 1'b1;
        end

        if ((r_state == ST_SCAN) && r_issuing) begin
            r_pidx <= r_idx;
        end

        // first matching channel of each kind
        if ((r_state == ST_SCAN) && r_pv) begin
            if (!r_idle_found && flags.idle) begin
                r_idle_ch <= r_pidx;
            end
            if (!r_diff_found && flags.diff) begin
                r_diff_ch <= r_pidx;
            end
            if (!r_hi_found && flags.high_ok) begin
                r_hi_ch <= r_pidx;
            end
        end

        if (r_state == ST_DECIDE) begin
            r_res.granted <= dec_granted;
            r_res.channel <= dec_granted ? pva_pkg::CHAN_OUT_W'(dec_pick) : '0;
            r_res.outcome <= dec_outcome;
        end

        if ((r_state == ST_DONE) && out_free) begin
            r_out <= r_res;
        end
    end

    `PVA_ASSERT(a_issue_in_range, i_clk, i_rst_n,
        r_issuing |-> (r_idx <= LAST_CH), "scan index past last channel")
    `PVA_ASSERT(a_return_in_scan, i_clk, i_rst_n,
        r_pv |-> (r_state == ST_SCAN), "scan data returned outside the scan")
    `PVA_ASSERT(a_decide_one_cycle, i_clk, i_rst_n,
        (r_state == ST_DECIDE) |=> (r_state == ST_DONE),
        "decision did not end in the result state")
    `PVA_NEVER(a_write_in_idle, i_clk, i_rst_n,
        mem_we && ((r_state == ST_IDLE) || (r_state == ST_DONE)),
        "channel memory written outside scan or decision")
    `PVA_ASSERT(a_grant_code, i_clk, i_rst_n,
        (r_state == ST_DONE) |-> (r_res.granted == (r_res.outcome == pva_pkg::OUT_GRANTED)),
        "grant flag disagrees with outcome")

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

    // action code with no meaning to the block
    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         NUM_CHANNELS = pva_pkg::CHANNEL_COUNT_DEF;
    // settle time after the last answer, longer than a full play scan, plus margin
    localparam int         DRAIN_CYCLES = 25;

    typedef struct {
        logic [1:0]                  action;
        logic [pva_pkg::SOUND_W-1:0] sound_id;
        logic [pva_pkg::LEVEL_W-1:0] level;
        logic [3:0]                  done_channel;
    } t_voice_req;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic [1:0]                     i_action;
    logic [pva_pkg::SOUND_W-1:0]    i_sound_id;
    logic [pva_pkg::LEVEL_W-1:0]    i_level;
    logic [3:0]                     i_done_channel;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic                           o_granted;
    logic [pva_pkg::CHAN_OUT_W-1:0] o_channel;
    logic [2:0]                     o_outcome;
    logic                           i_cfg_we;
    logic [1:0]                     i_cfg_index;
    logic [pva_pkg::ELAPSED_W-1:0]  i_cfg_wdata;

    // shadow of the channel table and the registers
    logic [pva_pkg::SOUND_W-1:0]   chan_sound   [NUM_CHANNELS];
    logic                          chan_playing [NUM_CHANNELS];
    logic [pva_pkg::LEVEL_W-1:0]   chan_level   [NUM_CHANNELS];
    logic [pva_pkg::ELAPSED_W-1:0] chan_elapsed [NUM_CHANNELS];
    logic                          cfg_audio_on;
    logic [pva_pkg::ELAPSED_W-1:0] cfg_dup_window;
    logic [pva_pkg::COUNT_W-1:0]   cfg_sound_count;

    pva_pkg::t_result pending_grants[$];
    int               mismatch_count = 0;
    bit               smooth_flow = 1'b0;

    priority_voice_allocator u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_sound_id     (i_sound_id),
        .i_level        (i_level),
        .i_done_channel (i_done_channel),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_granted      (o_granted),
        .o_channel      (o_channel),
        .o_outcome      (o_outcome),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        mismatch_count++;
    endtask

    // Apply one request to the shadow table and return the answer it should get.
    function automatic pva_pkg::t_result allocate_voice(input t_voice_req req);
        pva_pkg::t_result res;
        int               pick;
        int               diff;
        bit               refused;
        pick    = -1;
        diff    = -1;
        refused = 1'b0;
        res.granted = 1'b0;
        res.channel = '0;
        res.outcome = pva_pkg::OUT_NOT_PLAY;
        case (req.action)
            pva_pkg::ACT_PLAY: begin
                if (!cfg_audio_on) begin
                    res.outcome = pva_pkg::OUT_DISABLED;
                    refused = 1'b1;
                end else if (req.sound_id >= cfg_sound_count) begin
                    res.outcome = pva_pkg::OUT_BAD_ID;
                    refused = 1'b1;
                end
                // repeated low/lowest sound inside the window
                if (!refused && (req.level == pva_pkg::LVL_LOWEST ||
                                 req.level == pva_pkg::LVL_LOW)) begin
                    for (int i = 0; i < NUM_CHANNELS; i++)
                        if (chan_playing[i] && chan_sound[i] == req.sound_id &&
                            chan_elapsed[i] <= cfg_dup_window) refused = 1'b1;
                    if (refused) res.outcome = pva_pkg::OUT_DUPLICATE;
                end
                if (!refused && req.level == pva_pkg::LVL_HIGHEST) begin
                    for (int i = 0; i < NUM_CHANNELS; i++) begin
                        if (!chan_playing[i] && pick < 0) pick = i;
                        if (chan_sound[i] != req.sound_id && diff < 0) diff = i;
                    end
                    if (pick < 0) pick = diff;
                end else if (!refused) begin
                    if (req.level == pva_pkg::LVL_LOWEST || req.level == pva_pkg::LVL_HIGH) begin
                        for (int i = 0; i < NUM_CHANNELS; i++)
                            if (chan_playing[i] && chan_sound[i] == req.sound_id)
                                refused = 1'b1;
                        if (refused) res.outcome = pva_pkg::OUT_PLAYING;
                    end
                    for (int i = 0; i < NUM_CHANNELS; i++) begin
                        if (!refused && pick < 0) begin
                            if (req.level != pva_pkg::LVL_HIGH) begin
                                if (!chan_playing[i]) pick = i;
                            end else if (chan_level[i] < pva_pkg::LVL_HIGH ||
                                         (chan_level[i] == pva_pkg::LVL_HIGH &&
                                          !chan_playing[i])) begin
                                pick = i;
                            end
                        end
                    end
                end
                if (!refused) begin
                    if (pick < 0) begin
                        res.outcome = pva_pkg::OUT_NO_CHANNEL;
                    end else begin
                        chan_sound[pick]   = req.sound_id;
                        chan_playing[pick] = 1'b1;
                        chan_level[pick]   = req.level;
                        chan_elapsed[pick] = '0;
                        res.granted = 1'b1;
                        res.channel = pick[pva_pkg::CHAN_OUT_W-1:0];
                        res.outcome = pva_pkg::OUT_GRANTED;
                    end
                end
            end
            pva_pkg::ACT_TICK: begin
                for (int i = 0; i < NUM_CHANNELS; i++)
                    if (chan_playing[i] && chan_elapsed[i] != pva_pkg::ELAPSED_MAX)
                        chan_elapsed[i] = chan_elapsed[i] + 1'b1;
            end
            pva_pkg::ACT_END: begin
                if (req.done_channel < NUM_CHANNELS) chan_playing[req.done_channel] = 1'b0;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_voice_req make_req(input logic [1:0] act, input int id,
                                            input logic [1:0] lvl, input int done);
        t_voice_req req;
        req.action       = act;
        req.sound_id     = id[pva_pkg::SOUND_W-1:0];
        req.level        = lvl;
        req.done_channel = done[3:0];
        return req;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (smooth_flow || roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // a small pool of sounds so duplicates and busy sounds come up often
    function automatic int pick_sound();
        int roll;
        int edge_id;
        roll = $urandom_range(0, 99);
        if (roll < 60) return $urandom_range(0, 5);
        if (roll < 80) begin
            edge_id = int'(cfg_sound_count) - int'($urandom_range(0, 1));
            if (edge_id < 0) edge_id = 0;
            if (edge_id > pva_pkg::SOUND_IDS - 1) edge_id = pva_pkg::SOUND_IDS - 1;
            return edge_id;
        end
        return $urandom_range(0, pva_pkg::SOUND_IDS - 1);
    endfunction

    function automatic t_voice_req random_fields();
        return make_req(2'($urandom_range(0, 3)),
                        int'($urandom_range(0, pva_pkg::SOUND_IDS - 1)),
                        2'($urandom_range(0, 3)), int'($urandom_range(0, 15)));
    endfunction

    // Offer one request, hold it until accepted, then log its expected answer.
    task automatic send_request(input t_voice_req req);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action       = req.action;
        i_sound_id     = req.sound_id;
        i_level        = req.level;
        i_done_channel = req.done_channel;
        i_in_valid     = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_grants.push_back(allocate_voice(req));
    endtask

    // Stop offering, wait for every answer, then let the block settle.
    task automatic drain_requests();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input int value);
        drain_requests();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = value[pva_pkg::ELAPSED_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            pva_pkg::CFG_AUDIO_EN:   cfg_audio_on    = value[0];
            pva_pkg::CFG_DUP_WINDOW: cfg_dup_window  = value[pva_pkg::ELAPSED_W-1:0];
            pva_pkg::CFG_SOUND_CNT:  cfg_sound_count = value[pva_pkg::COUNT_W-1:0];
            default: ;
        endcase
    endtask

    // Level rules at the reset register values.
    task automatic test_level_rules();
        send_request(make_req(pva_pkg::ACT_PLAY, 0, pva_pkg::LVL_LOW, 0));
        send_request(make_req(pva_pkg::ACT_PLAY, 0, pva_pkg::LVL_LOW, 0));
        send_request(make_req(pva_pkg::ACT_PLAY, 0, pva_pkg::LVL_LOWEST, 0));
        send_request(make_req(pva_pkg::ACT_PLAY, 0, pva_pkg::LVL_HIGH, 0));
        send_request(make_req(pva_pkg::ACT_PLAY, 0, pva_pkg::LVL_HIGHEST, 0));
        send_request(make_req(pva_pkg::ACT_PLAY, 63, pva_pkg::LVL_LOWEST, 0));
        send_request(make_req(pva_pkg::ACT_TICK, 63, pva_pkg::LVL_HIGHEST, 15));
        send_request(make_req(pva_pkg::ACT_PLAY, 7, pva_pkg::LVL_HIGH, 0));
        send_request(make_req(pva_pkg::ACT_END, 0, pva_pkg::LVL_LOWEST, 1));
        send_request(make_req(pva_pkg::ACT_END, 0, pva_pkg::LVL_LOWEST, 15));
        send_request(make_req(ACT_UNUSED, 63, pva_pkg::LVL_HIGHEST, 15));
        send_request(make_req(pva_pkg::ACT_PLAY, 63, pva_pkg::LVL_HIGHEST, 0));
        send_request(make_req(pva_pkg::ACT_PLAY, 63, pva_pkg::LVL_HIGH, 0));
    endtask

    // Disabled audio and id range limits.
    task automatic test_config_refusals();
        write_register(pva_pkg::CFG_AUDIO_EN, 0);
        send_request(make_req(pva_pkg::ACT_PLAY, 9, pva_pkg::LVL_HIGHEST, 0));
        write_register(pva_pkg::CFG_AUDIO_EN, 1);
        write_register(pva_pkg::CFG_SOUND_CNT, 0);
        send_request(make_req(pva_pkg::ACT_PLAY, 0, pva_pkg::LVL_LOWEST, 0));
        write_register(pva_pkg::CFG_SOUND_CNT, 10);
        send_request(make_req(pva_pkg::ACT_PLAY, 10, pva_pkg::LVL_HIGH, 0));
        send_request(make_req(pva_pkg::ACT_PLAY, 9, pva_pkg::LVL_HIGH, 0));
        write_register(pva_pkg::CFG_SOUND_CNT, 64);
    endtask

    // Window edge: a repeat is refused at elapsed equal to the window, free one tick later.
    task automatic test_dup_window();
        write_register(pva_pkg::CFG_DUP_WINDOW, 3);
        send_request(make_req(pva_pkg::ACT_PLAY, 40, pva_pkg::LVL_LOW, 0));
        repeat (3) send_request(make_req(pva_pkg::ACT_TICK, 0, pva_pkg::LVL_LOWEST, 0));
        send_request(make_req(pva_pkg::ACT_PLAY, 40, pva_pkg::LVL_LOW, 0));
        send_request(make_req(pva_pkg::ACT_TICK, 0, pva_pkg::LVL_LOWEST, 0));
        send_request(make_req(pva_pkg::ACT_PLAY, 40, pva_pkg::LVL_LOW, 0));
        send_request(make_req(pva_pkg::ACT_PLAY, 40, pva_pkg::LVL_LOWEST, 0));
        write_register(pva_pkg::CFG_DUP_WINDOW, 0);
        send_request(make_req(pva_pkg::ACT_PLAY, 40, pva_pkg::LVL_HIGHEST, 0));
        send_request(make_req(pva_pkg::ACT_PLAY, 40, pva_pkg::LVL_LOW, 0));
    endtask

    // Random traffic: plays on a small sound pool, tick bursts, channel ends,
    // repeated sounds at mixed levels, and some fully random requests.
    task automatic test_random_traffic(input int n_items, input bit quiet);
        t_voice_req req;
        int         sent;
        int         roll;
        int         burst;
        int         id;
        sent        = 0;
        smooth_flow = quiet;
        while (sent < n_items) begin
            roll = $urandom_range(0, 99);
            req  = random_fields();
            if (roll < 45) begin
                id           = pick_sound();
                req.action   = pva_pkg::ACT_PLAY;
                req.sound_id = id[pva_pkg::SOUND_W-1:0];
                send_request(req);
                sent++;
            end else if (roll < 65) begin
                burst      = $urandom_range(1, 12);
                req.action = pva_pkg::ACT_TICK;
                repeat (burst) send_request(req);
                sent += burst;
            end else if (roll < 82) begin
                req.action = pva_pkg::ACT_END;
                send_request(req);
                sent++;
            end else if (roll < 90) begin
                id           = pick_sound();
                req.action   = pva_pkg::ACT_PLAY;
                req.sound_id = id[pva_pkg::SOUND_W-1:0];
                send_request(req);
                req.level = 2'($urandom_range(0, 3));
                send_request(req);
                sent += 2;
            end else begin
                send_request(req);
                sent++;
            end
        end
        smooth_flow = 1'b0;
    endtask

    task automatic test_register_sweep();
        write_register(pva_pkg::CFG_DUP_WINDOW, 50);
        test_random_traffic(300, 1'b0);
        write_register(pva_pkg::CFG_DUP_WINDOW, 0);
        write_register(pva_pkg::CFG_SOUND_CNT, 40);
        test_random_traffic(200, 1'b0);
        write_register(pva_pkg::CFG_DUP_WINDOW, 65535);
        write_register(pva_pkg::CFG_SOUND_CNT, 64);
        test_random_traffic(200, 1'b1);
        write_register(pva_pkg::CFG_DUP_WINDOW, 3);
        write_register(pva_pkg::CFG_SOUND_CNT, 1);
        test_random_traffic(150, 1'b0);
        write_register(pva_pkg::CFG_AUDIO_EN, 0);
        test_random_traffic(50, 1'b0);
        write_register(pva_pkg::CFG_AUDIO_EN, 1);
        write_register(pva_pkg::CFG_DUP_WINDOW, 8);
        write_register(pva_pkg::CFG_SOUND_CNT, 63);
        test_random_traffic(100, 1'b0);
    endtask

    // result side: random backpressure, with calm stretches
    initial begin
        int stall_left;
        int roll;
        stall_left  = 0;
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (smooth_flow) begin
                stall_left  = 0;
                i_out_ready = 1'b1;
            end else if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = 1'b1;
                roll = $urandom_range(0, 99);
                if (roll < 15) stall_left = $urandom_range(1, 3);
                else if (roll < 18) stall_left = $urandom_range(10, 40);
            end
        end
    end

    // compare every taken answer with the oldest one predicted
    always @(posedge i_clk) begin
        pva_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_grants.size() == 0) begin
                report_mismatch("unexpected answer", 0, 1);
            end else begin
                want = pending_grants.pop_front();
                if (o_granted !== want.granted)
                    report_mismatch("granted", want.granted, o_granted);
                if (o_channel !== want.channel)
                    report_mismatch("channel", want.channel, o_channel);
                if (o_outcome !== want.outcome)
                    report_mismatch("outcome", want.outcome, o_outcome);
            end
        end
    end

    initial begin
        #200_000_000;
        $display("priority_voice_allocator verification failed");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_action       = pva_pkg::ACT_PLAY;
        i_sound_id     = '0;
        i_level        = pva_pkg::LVL_LOWEST;
        i_done_channel = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = pva_pkg::CFG_AUDIO_EN;
        i_cfg_wdata    = '0;
        cfg_audio_on    = 1'b1;
        cfg_dup_window  = pva_pkg::DUP_WINDOW_RST;
        cfg_sound_count = pva_pkg::SOUND_CNT_RST;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            chan_sound[i]   = '0;
            chan_playing[i] = 1'b0;
            chan_level[i]   = pva_pkg::LVL_LOWEST;
            chan_elapsed[i] = '0;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_level_rules();
        test_config_refusals();
        test_dup_window();
        test_register_sweep();
        drain_requests();

        if (mismatch_count == 0) begin
            $display("priority_voice_allocator verification clean");
        end else begin
            $display("priority_voice_allocator verification failed");
        end
        $finish;
    end

endmodule
